FILE: rtl/smme_pkg.sv
package smme_pkg;

  localparam int SAMPLE_W = 8;
  localparam int CHAR_W   = 7;
  localparam int MARKER_W = 21;
  localparam int PLANE_W  = 3;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [MARKER_W-1:0] MARKER_RST = 21'd1320259;
  localparam logic [PLANE_W-1:0]  PLANE_RST  = 3'd0;

  typedef enum logic {
    REG_MARKER = 1'b0,
    REG_PLANE  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [MARKER_W-1:0] marker;
    logic [PLANE_W-1:0]  plane;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              is_verdict;
    logic              message_valid;
  } res_t;

  typedef struct packed {
    logic              char_v;
    logic              verdict_v;
    logic [CHAR_W-1:0] ch;
    logic              msg_ok;
  } push_t;

endpackage

FILE: rtl/smme_if.sv
interface smme_in_if import smme_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface smme_out_if import smme_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              is_verdict;
  logic              message_valid;

  modport source (output valid, output out_char, output is_verdict, output message_valid,
                  input ready);
  modport sink   (input valid, input out_char, input is_verdict, input message_valid,
                  output ready);
endinterface

FILE: rtl/stego_marker_message_extract.sv
// Flow: an accepted sample is held in the input register; its result beats enter the result queue
// when that register advances, and the output then presents them from the queue.
// Throughput: one sample per cycle; the input register advances while the four-entry result
// queue holds at most two beats, so the input stalls only under output back-pressure.
// Reset: synchronous active-low rst_n clears the window, counters and queue and restores
// the marker and bit-plane registers to their defaults.
module stego_marker_message_extract import smme_pkg::*; #(
  parameter int MARKER_LEN = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  smme_in_if.sink           in_bus,
  smme_out_if.source        out_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  push_t push;
  logic  room;

  smme_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smme_core #(
    .MARKER_LEN (MARKER_LEN)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_bus (in_bus),
    .room   (room),
    .push   (push)
  );

  smme_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .out_bus (out_bus)
  );

endmodule

FILE: rtl/smme_regs.sv
module smme_regs import smme_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [MARKER_W-1:0] marker_r;
  logic [PLANE_W-1:0]  plane_r;
  logic                wr_en;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RST;
      plane_r  <= PLANE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MARKER: marker_r <= pwdata[MARKER_W-1:0];
        REG_PLANE:  plane_r  <= pwdata[PLANE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MARKER: prdata = {{(DATA_W-MARKER_W){1'b0}}, marker_r};
      REG_PLANE:  prdata = {{(DATA_W-PLANE_W){1'b0}}, plane_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.marker = marker_r;
  assign cfg.plane  = plane_r;

endmodule

FILE: rtl/smme_core.sv
module smme_core import smme_pkg::*; #(
  parameter int MARKER_LEN = 21
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  smme_in_if.sink    in_bus,
  input  logic       room,
  output push_t      push
);

  localparam int FW = $clog2(MARKER_LEN + 1);
  localparam logic [FW-1:0] FULL = FW'(MARKER_LEN);

  logic                  vld_r;
  logic [SAMPLE_W-1:0]   smp_r;
  logic                  last_r;
  logic                  adv;
  logic                  in_acc;

  logic [MARKER_LEN-1:0] win_r, win_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [FW-1:0]         skip_r, skip_nxt;
  logic [1:0]            seen_r, seen_nxt;
  logic [CHAR_W-1:0]     shift_r, shift_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic [MARKER_LEN-1:0] marker_w;

  logic                  bit_in;
  logic                  full_before;
  logic                  match;
  logic [CHAR_W-1:0]     shift_t;

  generate
    if (MARKER_LEN > MARKER_W) begin : g_ext
      assign marker_w = {{(MARKER_LEN-MARKER_W){1'b0}}, cfg.marker};
    end else if (MARKER_LEN == MARKER_W) begin : g_eq
      assign marker_w = cfg.marker;
    end else begin : g_trunc
      assign marker_w = cfg.marker[MARKER_LEN-1:0];
    end
  endgenerate

  assign adv          = vld_r && room;
  assign in_bus.ready = !vld_r || adv;
  assign in_acc       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_acc) begin
      vld_r <= 1'b1;
    end else if (adv) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r  <= in_bus.sample;
      last_r <= in_bus.last_sample;
    end
  end

  always_comb begin
    bit_in      = smp_r[cfg.plane];
    full_before = (fill_r == FULL);
    win_nxt     = {win_r[MARKER_LEN-2:0], bit_in};
    fill_nxt    = full_before ? fill_r : fill_r + 1'b1;
    skip_nxt    = skip_r;
    seen_nxt    = seen_r;
    shift_nxt   = shift_r;
    cnt_nxt     = cnt_r;
    shift_t     = {shift_r[CHAR_W-2:0], win_r[MARKER_LEN-1]};
    push        = '0;

    // message bits leave the window MARKER_LEN samples late
    if (full_before && seen_r == 2'd1) begin
      if (skip_r != '0) begin
        skip_nxt = skip_r - 1'b1;
      end else if (cnt_r == 3'(CHAR_W - 1)) begin
        push.char_v = 1'b1;
        push.ch     = shift_t;
        shift_nxt   = '0;
        cnt_nxt     = '0;
      end else begin
        shift_nxt = shift_t;
        cnt_nxt   = cnt_r + 1'b1;
      end
    end

    match = (fill_nxt == FULL) && (win_nxt == marker_w);
    if (match) begin
      if (seen_r != 2'd3) begin
        seen_nxt = seen_r + 1'b1;
      end
      if (seen_r == 2'd0) begin
        skip_nxt  = FULL;
        shift_nxt = '0;
        cnt_nxt   = '0;
      end
    end

    if (last_r) begin
      push.verdict_v = 1'b1;
      push.msg_ok    = (seen_nxt == 2'd2);
      win_nxt        = '0;
      fill_nxt       = '0;
      skip_nxt       = '0;
      seen_nxt       = '0;
      shift_nxt      = '0;
      cnt_nxt        = '0;
    end

    if (!adv) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      fill_r  <= '0;
      skip_r  <= '0;
      seen_r  <= '0;
      shift_r <= '0;
      cnt_r   <= '0;
    end else if (adv) begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      skip_r  <= skip_nxt;
      seen_r  <= seen_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 3'(CHAR_W))
    else $error("char bit count out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("window fill overran");

  a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push.verdict_v |=> (seen_r == 2'd0 && fill_r == '0 && cnt_r == '0))
    else $error("state not cleared after verdict");

  a_push_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (push.char_v || push.verdict_v) |-> adv)
    else $error("result produced without an item");

endmodule

FILE: rtl/smme_outq.sv
module smme_outq import smme_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       room,
  smme_out_if.source out_bus
);

  localparam int DEPTH = 4;

  res_t       mem [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop;
  logic [1:0] n_push;
  res_t       ent_a, ent_b;

  assign room = (cnt_r <= 3'd2);
  assign pop  = out_bus.valid && out_bus.ready;

  assign n_push = {1'b0, push.char_v} + {1'b0, push.verdict_v};

  always_comb begin
    ent_b.out_char      = '0;
    ent_b.is_verdict    = 1'b1;
    ent_b.message_valid = push.msg_ok;
    if (push.char_v) begin
      ent_a.out_char      = push.ch;
      ent_a.is_verdict    = 1'b0;
      ent_a.message_valid = 1'b0;
    end else begin
      ent_a = ent_b;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wp_r] <= ent_a;
    end
    if (n_push == 2'd2) begin
      mem[wp_r + 2'd1] <= ent_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_push;
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, n_push} - {2'b0, pop};
    end
  end

  assign out_bus.valid         = (cnt_r != 3'd0);
  assign out_bus.out_char      = mem[rp_r].out_char;
  assign out_bus.is_verdict    = mem[rp_r].is_verdict;
  assign out_bus.message_valid = mem[rp_r].message_valid;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0) |-> room)
    else $error("result queue overflow");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(DEPTH))
    else $error("result queue count out of range");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push == 2'd0 && !pop) |=> $stable(cnt_r))
    else $error("queue count moved while idle");

endmodule
